// File: rtl/scsc_pkg.sv
package scsc_pkg;

  localparam int NUM_BINS_DEF   = 4;
  localparam int BIN_DEPTH_DEF  = 8;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int CAP_W = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_BIN_CAPACITY = 1'b0;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [30:0]        size_bytes;
    logic signed [31:0] in_seg_id;
    logic [31:0]        in_attach_addr;
    logic [31:0]        in_gpu_addr;
    logic [31:0]        in_heap_addr;
  } req_word_t;

  typedef struct packed {
    logic        ok;
    logic [30:0] out_seg_id;
    logic [31:0] out_attach_addr;
    logic [31:0] out_gpu_addr;
    logic [31:0] out_heap_addr;
  } rsp_word_t;

  typedef struct packed {
    logic [30:0] seg_id;
    logic [31:0] attach_addr;
    logic [31:0] gpu_addr;
    logic [31:0] heap_addr;
  } entry_t;

endpackage

// File: rtl/size_class_segment_cache_unit.sv
// add, flush and refused commands: the result is registered as the word is accepted
// get hit: the entry memory read is registered, then the result when the output is free
// throughput: 1 word per cycle for add and flush unless stalled; get hits block new words
// rst is synchronous, active high: clears all bin fill counts and sets bin_capacity to 8
// the entry memory is not cleared; entries at or above a bin's fill count are never read
module size_class_segment_cache_unit #(
  parameter int NUM_BINS   = scsc_pkg::NUM_BINS_DEF,
  parameter int BIN_DEPTH  = scsc_pkg::BIN_DEPTH_DEF,
  parameter int PAGE_BYTES = scsc_pkg::PAGE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  scsc_pkg::req_word_t         req_word,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output scsc_pkg::rsp_word_t         rsp_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scsc_pkg::APB_AW-1:0] paddr,
  input  logic [scsc_pkg::APB_DW-1:0] pwdata,
  output logic [scsc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  import scsc_pkg::*;

  localparam int BW    = $clog2(NUM_BINS);
  localparam int FW    = $clog2(BIN_DEPTH + 1);
  localparam int SLOTS = NUM_BINS * BIN_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int CMPW  = (FW > CAP_W) ? FW : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t           state;
  logic [FW-1:0]    bin_fill [NUM_BINS];
  logic [CAP_W-1:0] bin_capacity;
  logic             size_ok;
  logic [BW-1:0]    bin;
  logic [FW-1:0]    fill_cur;
  logic             has_room;
  logic             add_ok;
  logic             get_hit;
  logic             accept;
  logic             out_free;
  logic [AW-1:0]    slot_base;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  entry_t           wr_entry;
  entry_t           rd_entry;
  rsp_word_t        rsp_word_next;

  scsc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .bin_capacity (bin_capacity)
  );

  scsc_size_dec #(
    .NUM_BINS   (NUM_BINS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_size_dec (
    .size_bytes (req_word.size_bytes),
    .size_ok    (size_ok),
    .bin        (bin)
  );

  scsc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign req_stall = (state == ST_READ) | (rsp_valid & rsp_stall);
  assign accept    = req_valid & ~req_stall;
  assign out_free  = ~rsp_valid | ~rsp_stall;

  assign fill_cur  = bin_fill[bin];
  assign has_room  = (CMPW'(fill_cur) < CMPW'(bin_capacity)) &&
                     (CMPW'(fill_cur) < CMPW'(BIN_DEPTH));
  assign add_ok    = ~req_word.in_seg_id[31] && (req_word.in_attach_addr != '0) &&
                     size_ok && has_room;
  assign get_hit   = size_ok && (fill_cur != '0);
  assign slot_base = AW'(bin) * AW'(BIN_DEPTH);

  assign ram_we    = accept && (req_word.cmd == CMD_ADD) && add_ok;
  assign ram_re    = accept && (req_word.cmd == CMD_GET) && get_hit;
  assign ram_waddr = slot_base + AW'(fill_cur);
  assign ram_raddr = slot_base + AW'(fill_cur - FW'(1));

  assign wr_entry.seg_id      = req_word.in_seg_id[30:0];
  assign wr_entry.attach_addr = req_word.in_attach_addr;
  assign wr_entry.gpu_addr    = req_word.in_gpu_addr;
  assign wr_entry.heap_addr   = req_word.in_heap_addr;

  // result of a command that does not read the memory
  always_comb begin
    rsp_word_next = '0;
    case (req_word.cmd)
      CMD_ADD: begin
        rsp_word_next.ok = add_ok;
      end
      CMD_FLUSH: begin
        rsp_word_next.ok = 1'b1;
      end
      default: begin
        rsp_word_next.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bin_fill[i] <= '0;
      end
    end else if (accept) begin
      if (req_word.cmd == CMD_FLUSH) begin
        for (int i = 0; i < NUM_BINS; i++) begin
          bin_fill[i] <= '0;
        end
      end else if (ram_we) begin
        bin_fill[bin] <= fill_cur + FW'(1);
      end else if (ram_re) begin
        bin_fill[bin] <= fill_cur - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ram_re) begin
            state     <= ST_READ;
            rsp_valid <= 1'b0;
          end else if (accept) begin
            rsp_valid <= 1'b1;
          end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
          end
        end
        ST_READ: begin
          if (out_free) begin
            state     <= ST_IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          rsp_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && !ram_re) begin
      rsp_word <= rsp_word_next;
    end else if (state == ST_READ && out_free) begin
      rsp_word.ok              <= 1'b1;
      rsp_word.out_seg_id      <= rd_entry.seg_id;
      rsp_word.out_attach_addr <= rd_entry.attach_addr;
      rsp_word.out_gpu_addr    <= rd_entry.gpu_addr;
      rsp_word.out_heap_addr   <= rd_entry.heap_addr;
    end
  end

`ifndef ASSERT_OFF
  a_read_then_wait: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (state == ST_READ) && !rsp_valid)
    else $error("get hit did not enter the read state");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("entry memory written and read in one cycle");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_word.ok) |-> (rsp_word.out_seg_id == '0) &&
      (rsp_word.out_attach_addr == '0) && (rsp_word.out_gpu_addr == '0) &&
      (rsp_word.out_heap_addr == '0))
    else $error("refused or missed word carries nonzero fields");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CMPW'(fill_cur) < CMPW'(BIN_DEPTH)))
    else $error("push into a full bin");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (CMPW'(bin_fill[bin]) <= CMPW'(BIN_DEPTH)))
    else $error("bin fill above depth");
`endif

endmodule

// File: rtl/scsc_ram.sv
module scsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/scsc_size_dec.sv
module scsc_size_dec #(
  parameter int NUM_BINS   = 4,
  parameter int PAGE_BYTES = 4096
) (
  input  logic [30:0]                 size_bytes,
  output logic                        size_ok,
  output logic [$clog2(NUM_BINS)-1:0] bin
);

  localparam int BW = $clog2(NUM_BINS);
  localparam logic [31:0] SIZE_LIMIT = 32'((NUM_BINS - 1) * PAGE_BYTES);

  logic [31:0] size_ext;

  assign size_ext = {1'b0, size_bytes};

  // page threshold compares, the highest one passed names the bin
  always_comb begin
    bin = '0;
    for (int j = 1; j < NUM_BINS - 1; j++) begin
      if (size_ext > 32'(j * PAGE_BYTES)) begin
        bin = BW'(j);
      end
    end
    size_ok = (size_bytes != '0) && (size_ext <= SIZE_LIMIT);
  end

endmodule

// File: rtl/scsc_cfg.sv
module scsc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scsc_pkg::APB_AW-1:0] paddr,
  input  logic [scsc_pkg::APB_DW-1:0] pwdata,
  output logic [scsc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [scsc_pkg::CAP_W-1:0]  bin_capacity
);

  import scsc_pkg::*;

  logic [0:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[2:2];
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAP_RESET;
    end else if (wr_en && reg_index == REG_BIN_CAPACITY) begin
      bin_capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_BIN_CAPACITY) begin
      prdata = APB_DW'(bin_capacity);
    end
  end

endmodule

// File: tb/sv/size_class_segment_cache_unit_test.sv
module size_class_segment_cache_unit_test;
  import scsc_pkg::*;

  localparam int NB = NUM_BINS_DEF;
  localparam int DEPTH = BIN_DEPTH_DEF;
  localparam int PAGE = PAGE_BYTES_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_BIN_CAPACITY, 2'b00};
  localparam logic [APB_AW-1:0] UNUSED_ADDR = 3'd4;
  localparam int SEG_ITEMS = 88;

  class seg_cache_scoreboard;
    rsp_word_t pending_q[$];
    logic [CAP_W-1:0] capacity;
    int unsigned fill[NB];
    entry_t store[NB*DEPTH];
    int errors, words, stores, hits, refusals, flushes;

    function new();
      capacity = CAP_RESET;
      foreach (fill[i]) fill[i] = 0;
      errors = 0;
      words = 0;
      stores = 0;
      hits = 0;
      refusals = 0;
      flushes = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_request(req_word_t w);
      int unsigned pages, bin, slot, lim;
      logic size_ok;
      rsp_word_t want;
      pages = (32'(w.size_bytes) + PAGE - 1) / PAGE;
      size_ok = pages >= 1 && pages < NB;
      bin = size_ok ? pages - 1 : 0;
      lim = capacity < DEPTH ? capacity : DEPTH;
      want = '0;
      words++;
      case (w.cmd)
        CMD_ADD: begin
          if (!w.in_seg_id[31] && w.in_attach_addr != 0 && size_ok && fill[bin] < lim) begin
            slot = bin * DEPTH + fill[bin];
            store[slot].seg_id = w.in_seg_id[30:0];
            store[slot].attach_addr = w.in_attach_addr;
            store[slot].gpu_addr = w.in_gpu_addr;
            store[slot].heap_addr = w.in_heap_addr;
            fill[bin]++;
            want.ok = 1'b1;
            stores++;
          end else begin
            refusals++;
          end
        end
        CMD_GET: begin
          if (size_ok && fill[bin] != 0) begin
            fill[bin]--;
            slot = bin * DEPTH + fill[bin];
            want.ok = 1'b1;
            want.out_seg_id = store[slot].seg_id;
            want.out_attach_addr = store[slot].attach_addr;
            want.out_gpu_addr = store[slot].gpu_addr;
            want.out_heap_addr = store[slot].heap_addr;
            hits++;
          end else begin
            refusals++;
          end
        end
        CMD_FLUSH: begin
          foreach (fill[i]) fill[i] = 0;
          want.ok = 1'b1;
          flushes++;
        end
        default: begin
          refusals++;
        end
      endcase
      pending_q.push_back(want);
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(rsp_word_t got);
      rsp_word_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing pending %h", got));
      end else begin
        want = pending_q.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("ok %b, wanted %b", got.ok, want.ok));
        if (got.out_seg_id !== want.out_seg_id)
          report($sformatf("seg id %h, wanted %h", got.out_seg_id, want.out_seg_id));
        if (got.out_attach_addr !== want.out_attach_addr)
          report($sformatf("attach %h, wanted %h", got.out_attach_addr, want.out_attach_addr));
        if (got.out_gpu_addr !== want.out_gpu_addr)
          report($sformatf("gpu %h, wanted %h", got.out_gpu_addr, want.out_gpu_addr));
        if (got.out_heap_addr !== want.out_heap_addr)
          report($sformatf("heap %h, wanted %h", got.out_heap_addr, want.out_heap_addr));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_word_t req_word = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_word_t rsp_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  int tx_idle_pct = 7;
  int rx_idle_pct = 80;
  seg_cache_scoreboard sb = new();

  size_class_segment_cache_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_word(req_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word(rsp_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_word);
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic req_word_t make_word(logic [1:0] cmd, logic [30:0] size,
                                          logic [31:0] id, logic [31:0] attach,
                                          logic [31:0] gpu, logic [31:0] heap);
    req_word_t w;
    w.cmd = cmd;
    w.size_bytes = size;
    w.in_seg_id = id;
    w.in_attach_addr = attach;
    w.in_gpu_addr = gpu;
    w.in_heap_addr = heap;
    return w;
  endfunction

  function automatic req_word_t random_word();
    req_word_t w;
    int r;
    int pick;
    r = $urandom_range(99);
    w.cmd = CMD_ADD;
    w.size_bytes = 31'($urandom_range(2) * PAGE + $urandom_range(PAGE, 1));
    w.in_seg_id = $urandom & 32'h7FFF_FFFF;
    w.in_attach_addr = $urandom;
    if (w.in_attach_addr == 0) w.in_attach_addr = 32'd1;
    w.in_gpu_addr = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
    w.in_heap_addr = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
    if (r < 48) begin
      w.cmd = CMD_ADD;
    end else if (r < 85) begin
      w.cmd = CMD_GET;
    end else if (r < 88) begin
      w.cmd = CMD_FLUSH;
    end else begin
      pick = $urandom_range(4);
      case (pick)
        0: begin
          w.cmd = CMD_UNUSED;
          w.size_bytes = 31'($urandom);
          w.in_seg_id = $urandom;
        end
        1: w.in_seg_id = w.in_seg_id | 32'h8000_0000;
        2: w.in_attach_addr = 32'd0;
        3: begin
          w.cmd = $urandom_range(1) ? CMD_ADD : CMD_GET;
          w.size_bytes = 31'($urandom_range(31'h7FFF_FFFF, (NB - 1) * PAGE + 1));
        end
        default: begin
          w.cmd = CMD_GET;
          w.size_bytes = '0;
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_word(req_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word <= w;
    do @(posedge clk); while (req_stall);
    sb.note_request(w);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [APB_AW-1:0] addr, logic [CAP_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= ($urandom & 32'hFFFF_FFF0) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == CAP_ADDR) sb.set_capacity(value);
  endtask

  task automatic directed_words();
    send_word(make_word(CMD_ADD, 31'd0, 32'd1, 32'd1, 32'd1, 32'd1));
    send_word(make_word(CMD_ADD, 31'h7FFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1));
    send_word(make_word(CMD_ADD, 31'd1, 32'h7FFF_FFFF, '1, '1, '1));
    send_word(make_word(CMD_ADD, 31'(PAGE), 32'd0, 32'd1, 32'd0, 32'd0));
    send_word(make_word(CMD_ADD, 31'(PAGE + 1), 32'h8000_0000, 32'd9, 32'd9, 32'd9));
    send_word(make_word(CMD_ADD, 31'(2 * PAGE), 32'd3, 32'd0, 32'd9, 32'd9));
    send_word(make_word(CMD_ADD, 31'(3 * PAGE), 32'd5, 32'h1234_5678, 32'd6, 32'd7));
    send_word(make_word(CMD_ADD, 31'(3 * PAGE + 1), 32'd6, 32'd1, 32'd1, 32'd1));
    send_word(make_word(CMD_UNUSED, '1, '1, '1, '1, '1));
    send_word(make_word(CMD_GET, 31'd1, '0, '0, '0, '0));
    send_word(make_word(CMD_GET, 31'(PAGE), '0, '0, '0, '0));
    send_word(make_word(CMD_GET, 31'd4000, '0, '0, '0, '0));
    send_word(make_word(CMD_GET, 31'd0, '0, '0, '0, '0));
    send_word(make_word(CMD_GET, 31'(3 * PAGE + 1), '0, '0, '0, '0));
    send_word(make_word(CMD_GET, 31'd9000, '0, '0, '0, '0));
    send_word(make_word(CMD_ADD, 31'd5000, 32'd11, 32'd12, 32'd13, 32'd14));
    send_word(make_word(CMD_FLUSH, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_GET, 31'd5000, '0, '0, '0, '0));
    for (int i = 0; i <= DEPTH; i++)
      send_word(make_word(CMD_ADD, 31'(2048 + i), 32'(100 + i), 32'(200 + i),
                          $urandom, $urandom));
  endtask

  initial begin
    logic [CAP_W-1:0] caps[6];
    caps = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd8, 4'd5};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_words();
    drain();
    for (int s = 0; s < 6; s++) begin
      tx_idle_pct = (s < 2) ? 7 : (s < 4) ? 80 : 0;
      rx_idle_pct = (s < 2) ? 80 : (s < 4) ? 7 : 0;
      reg_write(CAP_ADDR, caps[s]);
      // a write to an unmapped address must leave the capacity alone
      if (s == 1) reg_write(UNUSED_ADDR, 4'd8);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i == SEG_ITEMS / 2) drain();
        send_word(random_word());
      end
      drain();
    end
    $display("covered %0d words: %0d stores, %0d get hits, %0d refused or missed, %0d flushes",
             sb.words, sb.stores, sb.hits, sb.refusals, sb.flushes);
    $display("capacities 8 3 0 15 1 8 5, sender and receiver stalls swapped, then none");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
rtl/scsc_pkg.sv
rtl/scsc_ram.sv
rtl/scsc_size_dec.sv
rtl/scsc_cfg.sv
rtl/size_class_segment_cache_unit.sv
tb/sv/size_class_segment_cache_unit_test.sv
